FILE: rtl/rdsc_pkg.sv
// shared types, constants and functions of the radix digit string converter
// no dependencies; used by every module of the block
package rdsc_pkg;

    // default sizes
    localparam int VALUE_BITS_DEF = 64;
    localparam int MAX_DIGITS_DEF = 64;
    localparam int MAX_BASE_DEF   = 16;

    // fixed field widths
    localparam int VALUE_W   = 64;
    localparam int RADIX_W   = 5;
    localparam int DIGIT_W   = 4;
    localparam int CHAR_W    = 8;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HIGH = 2'd2;

    // configuration reset values: radix ten, "01234567" and "89ABCDEF"
    localparam logic [RADIX_W-1:0] BASE_SIZE_RST  = 5'd10;
    localparam logic [CFG_W-1:0]   CHARS_LOW_RST  = 64'h3736353433323130;
    localparam logic [CFG_W-1:0]   CHARS_HIGH_RST = 64'h4645444342413938;

    // character of one digit from the two character tables
    function automatic logic [CHAR_W-1:0] digit_char(
        input logic [DIGIT_W-1:0] d,
        input logic [CFG_W-1:0]   chars_low,
        input logic [CFG_W-1:0]   chars_high
    );
        logic [CFG_W-1:0] chars;
        chars = d[3] ? chars_high : chars_low;
        return chars[{d[2:0], 3'b000} +: CHAR_W];
    endfunction

endpackage

FILE: rtl/rdsc_divider.sv
// shared restoring divider, one quotient bit per cycle
// depends on rdsc_pkg for the radix and digit widths
module rdsc_divider #(
    parameter int VALUE_BITS = rdsc_pkg::VALUE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [VALUE_BITS-1:0]         dividend,
    input  logic [rdsc_pkg::RADIX_W-1:0]  radix,
    output logic                          done,
    output logic [VALUE_BITS-1:0]         quotient,
    output logic [rdsc_pkg::DIGIT_W-1:0]  remainder
);

    localparam int STEP_W = $clog2(VALUE_BITS);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [STEP_W-1:0]            step_reg, step_next;
    logic [VALUE_BITS-1:0]        quo_reg, quo_next;
    logic [rdsc_pkg::DIGIT_W-1:0] rem_reg, rem_next;
    logic [rdsc_pkg::RADIX_W-1:0] shifted;
    logic [rdsc_pkg::RADIX_W-1:0] diff;
    logic                         ge;

    // one trial subtraction of the radix
    assign shifted = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign ge      = (shifted >= radix);
    assign diff    = shifted - radix;

    // step control
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(VALUE_BITS - 1);
            quo_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            quo_next = {quo_reg[VALUE_BITS-2:0], ge};
            rem_next = ge ? diff[rdsc_pkg::DIGIT_W-1:0] : shifted[rdsc_pkg::DIGIT_W-1:0];
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/rdsc_digit_mem.sv
// digit store: one write port, one read port with registered read data
// depends on rdsc_pkg for the digit width
module rdsc_digit_mem #(
    parameter int DEPTH = rdsc_pkg::MAX_DIGITS_DEF
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  logic [rdsc_pkg::DIGIT_W-1:0]  wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    output logic [rdsc_pkg::DIGIT_W-1:0]  rd_data
);

    logic [rdsc_pkg::DIGIT_W-1:0] mem [DEPTH];
    logic [rdsc_pkg::DIGIT_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/radix_digit_string_converter.sv
// top level of the radix digit string converter: sequencer and config registers
// depends on rdsc_pkg, rdsc_divider and rdsc_digit_mem
//
// Usage:
//   s_ channel (s_valid/s_ready/s_value) takes one unsigned number per
//   transaction; only its low VALUE_BITS bits are converted.
//   m_ channel (m_valid/m_ready) returns one character per transaction,
//   most significant digit first; m_last_digit marks the final character.
//   A zero value gives the single digit-zero character.
//   cfg_wr_en/cfg_index/cfg_wdata write base_size (0), digit_chars_low (1)
//   and digit_chars_high (2); write them only while the block is idle.
//   Base sizes below two act as two, above MAX_BASE as MAX_BASE.
// Operation:
//   each digit comes from the one shared bit-serial divider; all digits
//   of a number are divided first, then each character passes the read,
//   lookup and emit states; a stalled receiver holds the emit state.
//   s_ready is high only between numbers.
//   Numbers with more than MAX_DIGITS digits emit the low MAX_DIGITS digits.
// Reset:
//   synchronous, active low; restores the radix-ten table and goes idle.
//   A stalled receiver holds m_valid and the character until it is taken.
module radix_digit_string_converter #(
    parameter int VALUE_BITS = rdsc_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = rdsc_pkg::MAX_DIGITS_DEF,
    parameter int MAX_BASE   = rdsc_pkg::MAX_BASE_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [rdsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rdsc_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [rdsc_pkg::VALUE_W-1:0]    s_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rdsc_pkg::CHAR_W-1:0]     m_digit_char,
    output logic                            m_last_digit
);

    localparam int ADDR_W = $clog2(MAX_DIGITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_READ,
        ST_LOOKUP,
        ST_EMIT
    } state_t;

    state_t                        state_reg, state_next;
    logic [rdsc_pkg::RADIX_W-1:0]  radix_reg, radix_next;
    logic [ADDR_W-1:0]             idx_reg, idx_next;
    logic                          m_valid_reg, m_valid_next;
    logic [rdsc_pkg::CHAR_W-1:0]   m_digit_char_reg, m_digit_char_next;
    logic                          m_last_digit_reg, m_last_digit_next;

    logic [rdsc_pkg::RADIX_W-1:0]  base_size_reg;
    logic [rdsc_pkg::CFG_W-1:0]    chars_low_reg;
    logic [rdsc_pkg::CFG_W-1:0]    chars_high_reg;
    logic [rdsc_pkg::RADIX_W-1:0]  radix_eff;

    logic [VALUE_BITS-1:0]         value_in;
    logic                          div_start;
    logic [VALUE_BITS-1:0]         div_dividend;
    logic                          div_done;
    logic [VALUE_BITS-1:0]         div_quotient;
    logic [rdsc_pkg::DIGIT_W-1:0]  div_remainder;

    logic                          mem_wr_en;
    logic [ADDR_W-1:0]             mem_wr_addr;
    logic [rdsc_pkg::DIGIT_W-1:0]  mem_wr_data;
    logic                          mem_rd_en;
    logic [rdsc_pkg::DIGIT_W-1:0]  mem_rd_data;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_size_reg  <= rdsc_pkg::BASE_SIZE_RST;
            chars_low_reg  <= rdsc_pkg::CHARS_LOW_RST;
            chars_high_reg <= rdsc_pkg::CHARS_HIGH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rdsc_pkg::CFG_BASE_SIZE:  base_size_reg  <= cfg_wdata[rdsc_pkg::RADIX_W-1:0];
                rdsc_pkg::CFG_CHARS_LOW:  chars_low_reg  <= cfg_wdata;
                rdsc_pkg::CFG_CHARS_HIGH: chars_high_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // radix clamped to the usable range
    always_comb begin
        if (base_size_reg < rdsc_pkg::RADIX_W'(2)) begin
            radix_eff = rdsc_pkg::RADIX_W'(2);
        end else if (base_size_reg > rdsc_pkg::RADIX_W'(MAX_BASE)) begin
            radix_eff = rdsc_pkg::RADIX_W'(MAX_BASE);
        end else begin
            radix_eff = base_size_reg;
        end
    end

    assign value_in = s_value[VALUE_BITS-1:0];

    // sequencer next state
    always_comb begin
        state_next        = state_reg;
        radix_next        = radix_reg;
        idx_next          = idx_reg;
        m_valid_next      = m_valid_reg;
        m_digit_char_next = m_digit_char_reg;
        m_last_digit_next = m_last_digit_reg;
        div_start         = 1'b0;
        div_dividend      = div_quotient;
        mem_wr_en         = 1'b0;
        mem_wr_addr       = idx_reg;
        mem_wr_data       = div_remainder;
        mem_rd_en         = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    radix_next = radix_eff;
                    idx_next   = '0;
                    if (value_in == '0) begin
                        // zero is the single digit zero
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = '0;
                        mem_wr_data = '0;
                        state_next  = ST_READ;
                    end else begin
                        div_start    = 1'b1;
                        div_dividend = value_in;
                        state_next   = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    mem_wr_en = 1'b1;
                    if (div_quotient == '0 || idx_reg == ADDR_W'(MAX_DIGITS - 1)) begin
                        state_next = ST_READ;
                    end else begin
                        idx_next  = idx_reg + 1'b1;
                        div_start = 1'b1;
                    end
                end
            end
            ST_READ: begin
                mem_rd_en  = 1'b1;
                state_next = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                m_digit_char_next = rdsc_pkg::digit_char(mem_rd_data, chars_low_reg,
                                                         chars_high_reg);
                m_last_digit_next = (idx_reg == '0);
                m_valid_next      = 1'b1;
                state_next        = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_last_digit_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            idx_reg          <= '0;
            radix_reg        <= rdsc_pkg::BASE_SIZE_RST;
            m_digit_char_reg <= '0;
            m_last_digit_reg <= 1'b0;
        end else begin
            state_reg        <= state_next;
            m_valid_reg      <= m_valid_next;
            idx_reg          <= idx_next;
            radix_reg        <= radix_next;
            m_digit_char_reg <= m_digit_char_next;
            m_last_digit_reg <= m_last_digit_next;
        end
    end

    // shared divider
    rdsc_divider #(
        .VALUE_BITS(VALUE_BITS)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .radix     (radix_reg),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // digit store, least significant digit at index zero
    rdsc_digit_mem #(
        .DEPTH(MAX_DIGITS)
    ) u_digit_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (idx_reg),
        .rd_data (mem_rd_data)
    );

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_digit_char = m_digit_char_reg;
    assign m_last_digit = m_last_digit_reg;

endmodule

FILE: tb/sv/radix_digit_string_converter_tb.sv
// self-checking testbench for the radix digit string converter: numbers go in on the s_ channel,
// predicted characters are checked against the m_ channel across several radix and table settings
// depends on rdsc_pkg and radix_digit_string_converter
module radix_digit_string_converter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rdsc_pkg::*;

    localparam int LONG_HOLD_CYCLES = 1500;
    localparam int DRAIN_CYCLES     = 300;
    localparam int RANDOM_PHASES    = 12;

    // idle styles for both sides
    typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SOME} idle_style_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_item_t;

    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = CFG_BASE_SIZE;
    logic [CFG_W-1:0]     cfg_wdata    = '0;
    logic                 s_valid      = 1'b0;
    logic                 s_ready;
    logic [VALUE_W-1:0]   s_value      = '0;
    logic                 m_valid;
    logic                 m_ready      = 1'b0;
    logic [CHAR_W-1:0]    m_digit_char;
    logic                 m_last_digit;

    // numbers waiting to be offered and characters still to come back
    logic [VALUE_W-1:0] number_queue[$];
    char_item_t         pending_chars[$];

    // shadow copy of the configuration registers
    logic [RADIX_W-1:0] radix_setting = BASE_SIZE_RST;
    logic [CFG_W-1:0]   tbl_low       = CHARS_LOW_RST;
    logic [CFG_W-1:0]   tbl_high      = CHARS_HIGH_RST;

    idle_style_t idle_style   = IDLE_NONE;
    bit          s_taken      = 1'b0;
    bit          hold_request = 1'b0;
    int unsigned send_gap     = 0;
    int unsigned recv_gap     = 0;
    int unsigned hold_left    = 0;
    int unsigned mismatches   = 0;

    radix_digit_string_converter u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_digit_char(m_digit_char),
        .m_last_digit(m_last_digit)
    );

    always #10 aclk = ~aclk;

    // radix in force: small settings act as two, large ones as the table size
    function automatic int unsigned effective_radix();
        int unsigned radix;
        radix = radix_setting;
        if (radix < 2) radix = 2;
        if (radix > MAX_BASE_DEF) radix = MAX_BASE_DEF;
        return radix;
    endfunction

    // idle cycles before the next transaction on either side
    function automatic int unsigned draw_gap();
        case (idle_style)
            IDLE_FULL: return $urandom_range(0, 13);
            IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
            default:   return 0;
        endcase
    endfunction

    // split a number into digits and queue their characters, most significant first
    function automatic void predict_chars(input logic [VALUE_W-1:0] number);
        logic [DIGIT_W-1:0] digits[MAX_DIGITS_DEF];
        longint unsigned    quotient;
        int unsigned        radix;
        int                 n;
        char_item_t         item;
        radix    = effective_radix();
        quotient = number;
        if (VALUE_BITS_DEF < 64) quotient &= (64'd1 << VALUE_BITS_DEF) - 64'd1;
        n = 0;
        if (quotient == 0) begin
            digits[0] = '0;
            n = 1;
        end
        // only the lowest digits survive when the buffer runs out
        while (quotient != 0 && n < MAX_DIGITS_DEF) begin
            digits[n] = DIGIT_W'(quotient % radix);
            quotient  = quotient / radix;
            n++;
        end
        for (int k = n - 1; k >= 0; k--) begin
            if (digits[k][3]) item.ch = tbl_high[8 * int'(digits[k][2:0]) +: CHAR_W];
            else item.ch = tbl_low[8 * int'(digits[k][2:0]) +: CHAR_W];
            item.last = (k == 0);
            pending_chars.push_back(item);
        end
    endfunction

    // random number shaped to hit short, long and boundary digit strings
    function automatic logic [VALUE_W-1:0] rand_number();
        logic [VALUE_W-1:0] power;
        int unsigned        radix;
        int unsigned        steps;
        radix = effective_radix();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return {$urandom, $urandom};
            5, 6, 7: return {$urandom, $urandom} >> $urandom_range(0, 63);
            8:       return VALUE_W'($urandom_range(0, 300));
            default: begin
                // a power of the radix or one below it
                power = 1;
                steps = $urandom_range(1, 64);
                while (steps != 0 && power <= {VALUE_W{1'b1}} / radix) begin
                    power = power * radix;
                    steps--;
                end
                return power - VALUE_W'($urandom_range(0, 1));
            end
        endcase
    endfunction

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            CFG_BASE_SIZE:  radix_setting = data[RADIX_W-1:0];
            CFG_CHARS_LOW:  tbl_low       = data;
            CFG_CHARS_HIGH: tbl_high      = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // radix write with random junk above the register width
    task automatic write_radix(input logic [RADIX_W-1:0] radix);
        logic [CFG_W-1:0] word;
        word = {$urandom, $urandom};
        word[RADIX_W-1:0] = radix;
        write_cfg(CFG_BASE_SIZE, word);
    endtask

    task automatic wait_idle();
        while (number_queue.size() != 0 || s_valid || pending_chars.size() != 0)
            @(posedge aclk);
    endtask

    task automatic start_phase(input idle_style_t style);
        idle_style = style;
        @(posedge aclk);
    endtask

    // s_ channel: record accepted transactions and predict their characters
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            predict_chars(s_value);
            s_taken = 1'b1;
        end
    end

    // s_ channel driver: hold each number until taken, then idle for a drawn gap
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = draw_gap();
        end else if (!s_valid || s_taken) begin
            s_taken = 1'b0;
            if (send_gap != 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (number_queue.size() == 0) begin
                s_valid <= 1'b0;
            end else begin
                s_valid <= 1'b1;
                s_value <= number_queue.pop_front();
                send_gap = draw_gap();
            end
        end
    end

    // m_ channel monitor: compare each character transaction with the oldest prediction
    always @(posedge aclk) begin
        char_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected character: digit_char %h, last_digit %b",
                       m_digit_char, m_last_digit);
                mismatches++;
            end else begin
                want = pending_chars.pop_front();
                if (m_digit_char !== want.ch) begin
                    $error("digit_char: expected %h, actual %h", want.ch, m_digit_char);
                    mismatches++;
                end
                if (m_last_digit !== want.last) begin
                    $error("last_digit: expected %b, actual %b", want.last, m_last_digit);
                    mismatches++;
                end
            end
            recv_gap = draw_gap();
        end
    end

    // m_ channel ready: long hold-offs on request, otherwise drawn gaps after each transaction
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (recv_gap != 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // stimulus sequence
    initial begin
        int unsigned count;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset tables in radix ten
        start_phase(IDLE_NONE);
        number_queue.push_back(64'd0);
        number_queue.push_back(64'd1);
        number_queue.push_back(64'd9);
        number_queue.push_back(64'd10);
        number_queue.push_back(64'd99);
        number_queue.push_back({VALUE_W{1'b1}});
        number_queue.push_back(64'h8000_0000_0000_0000);
        number_queue.push_back(64'd10_000_000_000_000_000_000);
        wait_idle();

        // radix two, every digit slot used by the full range
        write_radix(5'd2);
        start_phase(IDLE_FULL);
        number_queue.push_back({VALUE_W{1'b1}});
        number_queue.push_back(64'h8000_0000_0000_0000);
        number_queue.push_back(64'd0);
        wait_idle();

        // radix sixteen with extreme tables
        write_radix(5'd16);
        write_cfg(CFG_CHARS_LOW, {CFG_W{1'b1}});
        write_cfg(CFG_CHARS_HIGH, '0);
        start_phase(IDLE_SOME);
        number_queue.push_back(64'h0123_4567_89AB_CDEF);
        number_queue.push_back(64'hFEDC_BA98_7654_3210);
        wait_idle();

        // radix settings outside the table clamp to the nearest legal radix
        write_cfg(CFG_CHARS_LOW, {$urandom, $urandom});
        write_cfg(CFG_CHARS_HIGH, {$urandom, $urandom});
        write_radix(5'd0);
        start_phase(IDLE_FULL);
        number_queue.push_back(64'd5);
        number_queue.push_back(64'd0);
        wait_idle();
        write_radix(5'd1);
        start_phase(IDLE_NONE);
        number_queue.push_back(64'hA5A5_A5A5_A5A5_A5A5);
        wait_idle();
        write_radix(5'd31);
        start_phase(IDLE_SOME);
        number_queue.push_back({VALUE_W{1'b1}});
        number_queue.push_back(64'h0123_4567_89AB_CDEF);
        wait_idle();
        write_radix(5'd17);
        start_phase(IDLE_FULL);
        number_queue.push_back(64'hFFFF);
        wait_idle();

        // random phases with fresh settings each time
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if ($urandom_range(0, 3) == 0) write_radix(RADIX_W'($urandom_range(0, 31)));
            else write_radix(RADIX_W'($urandom_range(2, MAX_BASE_DEF)));
            write_cfg(CFG_CHARS_LOW, {$urandom, $urandom});
            write_cfg(CFG_CHARS_HIGH, {$urandom, $urandom});
            start_phase(idle_style_t'(p % 3));
            // one phase stalls the receiver so the sender backs up
            if (p == 3) hold_request = 1'b1;
            count = $urandom_range(8, 12);
            repeat (count) number_queue.push_back(rand_number());
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("radix_digit_string_converter regression: pass");
        end else begin
            $display("radix_digit_string_converter regression: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #150ms;
        $display("radix_digit_string_converter regression: fail");
        $finish;
    end

endmodule
